// ----- design/tpme_pkg.sv -----
// ----------------------------------------------------------------------------
// tpme_pkg
// Shared types, constants and lookup tables for the touch pad MIDI encoder.
// ----------------------------------------------------------------------------
package tpme_pkg;

  localparam int unsigned PadCount = 32;
  localparam int unsigned PadW     = 5;

  typedef enum logic [2:0] {
    ROLE_KEY,
    ROLE_PROG,
    ROLE_OCT,
    ROLE_VEL,
    ROLE_EFF
  } role_e;

  // MIDI status bytes
  localparam logic [7:0] STATUS_NONE = 8'h00;
  localparam logic [7:0] STATUS_NOTE = 8'h90;
  localparam logic [7:0] STATUS_PROG = 8'hC0;
  localparam logic [7:0] STATUS_CTRL = 8'hB0;

  // message lengths
  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_PROG = 2'd2;
  localparam logic [1:0] LEN_FULL = 2'd3;

  localparam logic [6:0] CTRL_ON     = 7'h7F;
  localparam logic [6:0] PROG_MAX    = 7'd127;
  localparam logic [2:0] VEL_IDX_MAX = 3'd4;
  localparam logic [2:0] VEL_IDX_RST = 3'd2;
  localparam logic [7:0] OCT_STEP    = 8'd12;

  // octave offset, two's complement
  localparam logic [1:0] OCT_ZERO = 2'b00;
  localparam logic [1:0] OCT_UP   = 2'b01;
  localparam logic [1:0] OCT_DOWN = 2'b11;

  localparam logic [6:0] DIR_DOWN = 7'd0;
  localparam logic [6:0] DIR_UP   = 7'd1;

  typedef struct packed {
    role_e      role;
    logic [6:0] arg;   // base note, direction or controller number
  } pad_entry_t;

  typedef struct packed {
    logic [1:0] message_length;
    logic [7:0] status_byte;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic       octave_down_led;
    logic       octave_up_led;
    logic       activity_pulse;
  } result_t;

  function automatic pad_entry_t pad_lookup(logic [PadW-1:0] pad);
    pad_entry_t e;
    case (pad)
      5'd0:    e = '{ROLE_KEY,  7'h54};
      5'd1:    e = '{ROLE_OCT,  DIR_DOWN};
      5'd2:    e = '{ROLE_EFF,  7'h01};
      5'd3:    e = '{ROLE_PROG, DIR_DOWN};
      5'd4:    e = '{ROLE_PROG, DIR_UP};
      5'd5:    e = '{ROLE_VEL,  DIR_DOWN};
      5'd6:    e = '{ROLE_VEL,  DIR_UP};
      5'd7:    e = '{ROLE_OCT,  DIR_UP};
      // pads 8..31 are keys 0x3c..0x53
      default: e = '{ROLE_KEY,  7'h34 + {2'b00, pad}};
    endcase
    return e;
  endfunction

  function automatic logic [6:0] vel_lookup(logic [2:0] idx);
    logic [6:0] v;
    case (idx)
      3'd0:    v = 7'd60;
      3'd1:    v = 7'd80;
      3'd2:    v = 7'd100;
      3'd3:    v = 7'd114;
      default: v = 7'd127;  // index 4 and anything above
    endcase
    return v;
  endfunction

endpackage

// ----- design/touch_pad_midi_encoder_core.sv -----
// ----------------------------------------------------------------------------
// touch_pad_midi_encoder_core
// Turns pad press/release events into MIDI messages plus LED/activity status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one pad event per transfer (pad_index_i, pressed_i)
//   under in_valid_i / in_stall_o. Output channel carries one result per
//   event (message length, status byte, two data bytes, octave LEDs and an
//   activity pulse) under out_valid_o / out_stall_i. A transfer happens on a
//   rising edge with valid high and stall low.
//   Every event yields exactly one result, in order.
//   An input transfer reaches out_valid_o via the input register, then the
//   result register. Throughput: one event per cycle unless stalled; the
//   state update is a single pass of table lookup and small adds, so the
//   next event can sit in the input register while the previous one waits.
//   Reset (rst_ni low, async): both stages empty, held notes cleared to 0,
//   octave offset 0, velocity index 2, program 0.
//   When the receiver stalls, the result register holds; the input register
//   still fills once, then in_stall_o rises until the output drains.
// ----------------------------------------------------------------------------
module touch_pad_midi_encoder_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [tpme_pkg::PadW-1:0] pad_index_i,
  input  logic                      pressed_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                message_length_o,
  output logic [7:0]                status_byte_o,
  output logic [6:0]                data_first_o,
  output logic [6:0]                data_second_o,
  output logic                      octave_down_led_o,
  output logic                      octave_up_led_o,
  output logic                      activity_pulse_o
);
  import tpme_pkg::*;

  // input stage
  logic            s1_valid_q, s1_valid_d;
  logic [PadW-1:0] s1_pad_q;
  logic            s1_pressed_q;

  // output stage
  logic    out_valid_q, out_valid_d;
  result_t result_q;
  result_t result;

  logic in_xfer;
  logic out_free;
  logic advance;

  // output register can load when empty or being drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pad_q <= pad_index_i;
      s1_pressed_q <= pressed_i;
    end
    if (advance) begin
      result_q <= result;
    end
  end

  // state commits in the same cycle the result is captured
  tpme_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .update_i    (advance),
    .pad_index_i (s1_pad_q),
    .pressed_i   (s1_pressed_q),
    .result_o    (result)
  );

  assign out_valid_o       = out_valid_q;
  assign message_length_o  = result_q.message_length;
  assign status_byte_o     = result_q.status_byte;
  assign data_first_o      = result_q.data_first;
  assign data_second_o     = result_q.data_second;
  assign octave_down_led_o = result_q.octave_down_led;
  assign octave_up_led_o   = result_q.octave_up_led;
  assign activity_pulse_o  = result_q.activity_pulse;

endmodule

// ----- design/tpme_engine.sv -----
// ----------------------------------------------------------------------------
// tpme_engine
// Encoder state (held notes, octave, velocity, program) and the single-pass
// result logic for one pad event.
// ----------------------------------------------------------------------------
module tpme_engine (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     update_i,
  input  logic [tpme_pkg::PadW-1:0] pad_index_i,
  input  logic                     pressed_i,
  output tpme_pkg::result_t        result_o
);
  import tpme_pkg::*;

  logic [6:0] held_note_q [PadCount];
  logic [1:0] octave_q, octave_d;
  logic [2:0] vel_idx_q, vel_idx_d;
  logic [6:0] prog_q, prog_d;
  logic       note_we;
  logic [6:0] note_val;

  pad_entry_t entry;
  logic [7:0] note_sum;

  always_comb begin
    entry = pad_lookup(pad_index_i);
    case (octave_q)
      OCT_UP:   note_sum = {1'b0, entry.arg} + OCT_STEP;
      OCT_DOWN: note_sum = {1'b0, entry.arg} - OCT_STEP;
      default:  note_sum = {1'b0, entry.arg};
    endcase
    note_val = note_sum[6:0];
  end

  always_comb begin
    octave_d = octave_q;
    vel_idx_d = vel_idx_q;
    prog_d = prog_q;
    note_we = 1'b0;
    result_o = '0;
    if (pressed_i) begin
      case (entry.role)
        ROLE_KEY: begin
          note_we = 1'b1;
          result_o.message_length = LEN_FULL;
          result_o.status_byte = STATUS_NOTE;
          result_o.data_first = note_val;
          result_o.data_second = vel_lookup(vel_idx_q);
          result_o.activity_pulse = 1'b1;
        end
        ROLE_PROG: begin
          if (entry.arg == DIR_UP) begin
            if (prog_q != PROG_MAX) prog_d = prog_q + 7'd1;
          end else begin
            if (prog_q != 7'd0) prog_d = prog_q - 7'd1;
          end
          result_o.message_length = LEN_PROG;
          result_o.status_byte = STATUS_PROG;
          result_o.data_first = prog_d;
          result_o.activity_pulse = 1'b1;
        end
        ROLE_OCT: begin
          if (octave_q == OCT_ZERO) begin
            octave_d = (entry.arg == DIR_UP) ? OCT_UP : OCT_DOWN;
          end else begin
            octave_d = OCT_ZERO;
          end
        end
        ROLE_VEL: begin
          if (entry.arg == DIR_UP) begin
            if (vel_idx_q < VEL_IDX_MAX) begin
              vel_idx_d = vel_idx_q + 3'd1;
              result_o.activity_pulse = 1'b1;
            end
          end else begin
            if (vel_idx_q != 3'd0) begin
              vel_idx_d = vel_idx_q - 3'd1;
              result_o.activity_pulse = 1'b1;
            end
          end
        end
        default: begin
          result_o.message_length = LEN_FULL;
          result_o.status_byte = STATUS_CTRL;
          result_o.data_first = entry.arg;
          result_o.data_second = CTRL_ON;
          result_o.activity_pulse = 1'b1;
        end
      endcase
    end else begin
      case (entry.role)
        ROLE_KEY: begin
          result_o.message_length = LEN_FULL;
          result_o.status_byte = STATUS_NOTE;
          result_o.data_first = held_note_q[pad_index_i];
          result_o.activity_pulse = 1'b1;
        end
        ROLE_EFF: begin
          result_o.message_length = LEN_FULL;
          result_o.status_byte = STATUS_CTRL;
          result_o.data_first = entry.arg;
          result_o.activity_pulse = 1'b1;
        end
        default: begin
        end
      endcase
    end
    // LEDs show the offset after this event
    result_o.octave_down_led = (octave_d == OCT_DOWN);
    result_o.octave_up_led = (octave_d == OCT_UP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_q <= OCT_ZERO;
      vel_idx_q <= VEL_IDX_RST;
      prog_q <= 7'd0;
    end else if (update_i) begin
      octave_q <= octave_d;
      vel_idx_q <= vel_idx_d;
      prog_q <= prog_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PadCount; i++) begin
        held_note_q[i] <= 7'd0;
      end
    end else if (update_i && note_we) begin
      held_note_q[pad_index_i] <= note_val;
    end
  end

endmodule

// ----- design/tpme_checker.sv -----
// ----------------------------------------------------------------------------
// tpme_checker
// Port-level checks on the touch pad MIDI encoder, bound to the top level.
// ----------------------------------------------------------------------------
module tpme_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] message_length_o,
  input logic [7:0] status_byte_o,
  input logic [6:0] data_first_o,
  input logic [6:0] data_second_o,
  input logic       octave_down_led_o,
  input logic       octave_up_led_o,
  input logic       activity_pulse_o
);
  import tpme_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(message_length_o)
      && $stable(status_byte_o) && $stable(data_first_o) && $stable(data_second_o))
    else $error("stalled result changed");

  a_len_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> message_length_o == LEN_NONE || message_length_o == LEN_PROG
      || message_length_o == LEN_FULL)
    else $error("illegal message length");

  a_led_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(octave_down_led_o && octave_up_led_o))
    else $error("both octave LEDs lit");

  a_empty_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_length_o == LEN_NONE |->
      status_byte_o == STATUS_NONE && data_first_o == 7'd0 && data_second_o == 7'd0)
    else $error("empty message carries data");

  a_msg_activity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_length_o != LEN_NONE |-> activity_pulse_o)
    else $error("message without activity pulse");

endmodule

bind touch_pad_midi_encoder_core tpme_checker u_tpme_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .message_length_o  (message_length_o),
  .status_byte_o     (status_byte_o),
  .data_first_o      (data_first_o),
  .data_second_o     (data_second_o),
  .octave_down_led_o (octave_down_led_o),
  .octave_up_led_o   (octave_up_led_o),
  .activity_pulse_o  (activity_pulse_o)
);
